// ----- rtl/core/tolr_pkg.sv -----
package tolr_pkg;

    // Sample and fraction formats
    localparam int SAMPLE_BITS    = 32;
    localparam int FRAC_BITS      = 16;
    localparam int RATIO_INT_BITS = 30;
    localparam int VAR_BITS       = 3;
    localparam int THR_BITS       = 62;
    localparam int CFG_IDX_BITS   = 1;

    // Slopes are exact differences, ratios and limiter values carry a sign bit and headroom
    localparam int SLOPE_BITS  = SAMPLE_BITS + 1;
    localparam int RATIO_BITS  = RATIO_INT_BITS + FRAC_BITS + 2;
    localparam int RMAG_BITS   = RATIO_INT_BITS + FRAC_BITS;

    // Iterative divider: DIV_RADIX quotient bits per cycle while busy
    localparam int DIV_RADIX   = 3;
    localparam int DIV_STEPS   = (SLOPE_BITS + FRAC_BITS + DIV_RADIX - 1) / DIV_RADIX;
    localparam int DIV_BITS    = DIV_STEPS * DIV_RADIX;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    // Limiter value times slope is split into two partial products
    localparam int LM_HALF     = 22;
    localparam int MUL_BITS    = SLOPE_BITS;
    localparam int PROD_BITS   = 2 * MUL_BITS;
    localparam int ACC_BITS    = 2 * LM_HALF + SLOPE_BITS + 1;
    localparam int WIDE_BITS   = 64;

    // Division by six: halve, then multiply by the reciprocal of three, exact below 2^47
    localparam int RECIP_BITS  = 46;
    localparam int RECIP_HALF  = 23;
    localparam int RECIP_SHIFT = 47;
    localparam int BACC_BITS   = 2 * RECIP_BITS + 1;
    localparam logic [RECIP_BITS-1:0] RECIP_THIRD = 46'h2AAA_AAAA_AAAB;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_LIMITER_MODE    = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SMOOTH_THRESHOLD = 1'b1;

    // Fixed-point constants
    localparam logic signed [RATIO_BITS-1:0] FX_ONE = RATIO_BITS'(64'd1 << FRAC_BITS);
    localparam logic signed [RATIO_BITS-1:0] FX_TWO = RATIO_BITS'(64'd2 << FRAC_BITS);
    localparam logic signed [RATIO_BITS-1:0] FX_EIGHT_TENTHS =
        RATIO_BITS'((64'd8 * (64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [RMAG_BITS-1:0] RATIO_MAX = '1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [SLOPE_BITS-1:0]  t_slope;
    typedef logic signed [RATIO_BITS-1:0]  t_ratio;

    // One centre cell waiting for reconstruction
    typedef struct packed {
        t_sample             pl;
        t_sample             pc;
        t_sample             x;
        logic [VAR_BITS-1:0] var_index;
    } t_job;

    typedef struct packed {
        logic                  start;
        logic [DIV_BITS-1:0]   num;
        logic [SLOPE_BITS-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [DIV_BITS-1:0] quot;
    } t_div_rsp;

endpackage

// ----- rtl/core/tolr_fifo.sv -----
module tolr_fifo
    import tolr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_data,
    output logic o_empty
);

    localparam int DEPTH = 2;
    localparam int PTR_BITS = $clog2(DEPTH);

    t_job                r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [PTR_BITS:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == (PTR_BITS + 1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/core/tolr_front.sv -----
module tolr_front
    import tolr_pkg::*;
#(
    parameter int NUM_VARS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_sample             i_sample,
    input  logic [VAR_BITS-1:0] i_var_index,
    input  logic                i_line_start,
    input  logic                i_q_full,
    output logic                o_job_push,
    output t_job                o_job
);

    localparam int IDX_BITS = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

    t_sample             r_one [NUM_VARS];
    t_sample             r_two [NUM_VARS];
    logic [1:0]          r_cells;
    logic                accept;
    logic                in_range;
    logic [IDX_BITS-1:0] idx;
    logic [1:0]          seen;

    assign accept   = i_push && !i_q_full;
    assign in_range = (5'(i_var_index) < 5'(NUM_VARS));
    assign idx      = IDX_BITS'(i_var_index);
    assign seen     = i_line_start ? 2'd0 : r_cells;

    // A job is queued once two full cells of the slice precede the new sample
    assign o_job_push   = accept && in_range && (seen == 2'd2);
    assign o_job.pl     = r_two[idx];
    assign o_job.pc     = r_one[idx];
    assign o_job.x      = i_sample;
    assign o_job.var_index = i_var_index;

    // Cell count of the current slice
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells <= 2'd0;
        end else if (accept && in_range) begin
            if ((5'(i_var_index) == 5'(NUM_VARS - 1)) && (seen != 2'd2)) begin
                r_cells <= seen + 2'd1;
            end else begin
                r_cells <= seen;
            end
        end
    end

    // Sample history per variable
    always_ff @(posedge i_clk) begin
        if (accept && in_range) begin
            r_two[idx] <= r_one[idx];
            r_one[idx] <= i_sample;
        end
    end

endmodule

// ----- rtl/core/tolr_div.sv -----
module tolr_div
    import tolr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_BITS-1:0]     r_num;
    logic [SLOPE_BITS-1:0]   r_den;
    logic [SLOPE_BITS-1:0]   r_rem;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic                    r_busy;
    logic                    r_done;
    logic [DIV_BITS-1:0]     n_num;
    logic [SLOPE_BITS-1:0]   n_rem;

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;

    // Restoring division, DIV_RADIX quotient bits per cycle while busy; quotient shifts into the dividend
    always_comb begin
        logic [SLOPE_BITS:0] trial;
        n_num = r_num;
        n_rem = r_rem;
        for (int k = 0; k < DIV_RADIX; k++) begin
            trial = {n_rem, n_num[DIV_BITS-1]};
            n_num = {n_num[DIV_BITS-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                n_rem    = SLOPE_BITS'(trial - {1'b0, r_den});
                n_num[0] = 1'b1;
            end else begin
                n_rem = trial[SLOPE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= n_num;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/core/tolr_back.sv -----
module tolr_back
    import tolr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  t_job                i_job,
    output logic                o_job_pop,
    input  logic                i_limiter_mode,
    input  logic [THR_BITS-1:0] i_smooth_threshold,
    output t_div_req            o_div_req,
    input  t_div_rsp            i_div_rsp,
    output logic                o_empty,
    input  logic                i_pop,
    output t_sample             o_left_state,
    output t_sample             o_right_state,
    output logic [VAR_BITS-1:0] o_out_var_index
);

    typedef enum logic [4:0] {
        S_IDLE, S_SQ0, S_SQ1, S_SQ2,
        S_TH, S_THW, S_THI, S_THIW,
        S_B0, S_B1, S_B2, S_B3, S_B4, S_B5, S_B6, S_B7, S_B8,
        S_LIM, S_P0, S_P1, S_P2, S_P3, S_P4, S_FIN
    } t_state;

    t_state               r_state;
    t_sample              r_pc;
    t_slope               r_dl;
    t_slope               r_dr;
    logic [VAR_BITS-1:0]  r_var;
    logic                 r_steep;
    t_ratio               r_th;
    t_ratio               r_thi;
    t_ratio               r_br;
    t_ratio               r_bl;
    t_ratio               r_lmr;
    t_ratio               r_lml;
    logic [PROD_BITS-1:0] r_prod;
    logic [ACC_BITS-1:0]  r_acc;
    logic [ACC_BITS-1:0]  r_acc_r;
    logic [ACC_BITS-1:0]  r_acc_l;
    logic [BACC_BITS-1:0] r_bacc;
    logic                 r_out_valid;
    t_sample              r_left;
    t_sample              r_right;
    logic [VAR_BITS-1:0]  r_out_var;

    logic [SLOPE_BITS-1:0] mag_dl;
    logic [SLOPE_BITS-1:0] mag_dr;
    logic [RATIO_BITS-1:0] mag_lmr;
    logic [RATIO_BITS-1:0] mag_lml;
    logic [MUL_BITS-1:0]   mul_a;
    logic [MUL_BITS-1:0]   mul_b;
    t_ratio                sum_br;
    t_ratio                sum_bl;
    logic [RATIO_BITS-1:0] mag_sum_br;
    logic [RATIO_BITS-1:0] mag_sum_bl;
    logic [RECIP_BITS-1:0] half_br;
    logic [RECIP_BITS-1:0] half_bl;
    logic [BACC_BITS-1:0]  bsum;
    logic [RATIO_BITS-1:0] base_mag;
    logic                  out_free;
    logic signed [WIDE_BITS-1:0] prod_r;
    logic signed [WIDE_BITS-1:0] prod_l;

    function automatic logic [SLOPE_BITS-1:0] mag_slope(input t_slope a);
        return a[SLOPE_BITS-1] ? SLOPE_BITS'(-a) : SLOPE_BITS'(a);
    endfunction

    function automatic logic [RATIO_BITS-1:0] mag_ratio(input t_ratio a);
        return a[RATIO_BITS-1] ? RATIO_BITS'(-a) : RATIO_BITS'(a);
    endfunction

    // Saturated signed ratio from the raw quotient
    function automatic t_ratio ratio_out(input logic [DIV_BITS-1:0] q, input logic num_zero,
                                         input logic den_zero, input logic neg);
        logic [RMAG_BITS-1:0] m;
        if (den_zero || (q > DIV_BITS'(RATIO_MAX))) begin
            m = RATIO_MAX;
        end else begin
            m = q[RMAG_BITS-1:0];
        end
        if (num_zero) begin
            return '0;
        end
        return neg ? -t_ratio'({2'b00, m}) : t_ratio'({2'b00, m});
    endfunction

    function automatic t_ratio t_min(input t_ratio a, input t_ratio b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_ratio t_max(input t_ratio a, input t_ratio b);
        return (a > b) ? a : b;
    endfunction

    // Koren or LimO3 limiter value from the ratio and its smooth base
    function automatic t_ratio limit(input t_ratio t, input t_ratio base, input logic limo3,
                                     input logic steep);
        t_ratio quarter;
        t_ratio p;
        quarter = t[RATIO_BITS-1] ? -((-t) >>> 2) : (t >>> 2);
        if (!limo3) begin
            p = t_min(t_min(t, base), FX_ONE);
            return t_max(p, '0);
        end
        if (!steep) begin
            return base;
        end
        p = t_min(t, FX_EIGHT_TENTHS);
        p = t_min(base, p);
        p = t_max(-quarter, p);
        p = t_min(base, p);
        return t_max(p, '0);
    endfunction

    function automatic t_sample sat_sample(input logic signed [WIDE_BITS-1:0] v);
        if (v > signed'(WIDE_BITS'({1'b0, {(SAMPLE_BITS-1){1'b1}}}))) begin
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        if (v < -signed'(WIDE_BITS'({1'b1, {(SAMPLE_BITS-1){1'b0}}}))) begin
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    assign mag_dl     = mag_slope(r_dl);
    assign mag_dr     = mag_slope(r_dr);
    assign mag_lmr    = mag_ratio(r_lmr);
    assign mag_lml    = mag_ratio(r_lml);
    assign sum_br     = FX_TWO + r_th;
    assign sum_bl     = FX_TWO + r_thi;
    assign mag_sum_br = mag_ratio(sum_br);
    assign mag_sum_bl = mag_ratio(sum_bl);
    assign half_br    = RECIP_BITS'(mag_sum_br >> 1);
    assign half_bl    = RECIP_BITS'(mag_sum_bl >> 1);
    assign out_free   = !r_out_valid || i_pop;
    assign o_job_pop  = (r_state == S_IDLE) && i_job_valid;

    // Last partial product of the reciprocal multiplication gives the magnitude of sum / 6
    assign bsum     = r_bacc + (BACC_BITS'(r_prod) << (2 * RECIP_HALF));
    assign base_mag = RATIO_BITS'(bsum >> RECIP_SHIFT);

    assign o_empty         = !r_out_valid;
    assign o_left_state    = r_left;
    assign o_right_state   = r_right;
    assign o_out_var_index = r_out_var;

    // Products after the fraction shift, with the sign of the operands
    always_comb begin
        logic [WIDE_BITS-1:0] mr;
        logic [WIDE_BITS-1:0] ml;
        mr = WIDE_BITS'(r_acc_r >> FRAC_BITS);
        ml = WIDE_BITS'(r_acc_l >> FRAC_BITS);
        prod_r = (r_lmr[RATIO_BITS-1] != r_dr[SLOPE_BITS-1]) ? -signed'(mr) : signed'(mr);
        prod_l = (r_lml[RATIO_BITS-1] != r_dl[SLOPE_BITS-1]) ? -signed'(ml) : signed'(ml);
    end

    // Divider requests
    always_comb begin
        o_div_req = '0;
        case (r_state)
            S_TH: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = DIV_BITS'({mag_dl, {FRAC_BITS{1'b0}}});
                o_div_req.den   = mag_dr;
            end
            S_THI: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = DIV_BITS'({mag_dr, {FRAC_BITS{1'b0}}});
                o_div_req.den   = mag_dl;
            end
            default: begin
                o_div_req = '0;
            end
        endcase
    end

    // Operands of the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQ0: begin
                mul_a = mag_dl;
                mul_b = mag_dl;
            end
            S_SQ1: begin
                mul_a = mag_dr;
                mul_b = mag_dr;
            end
            S_B0: begin
                mul_a = MUL_BITS'(half_br[RECIP_HALF-1:0]);
                mul_b = MUL_BITS'(RECIP_THIRD[RECIP_HALF-1:0]);
            end
            S_B1: begin
                mul_a = MUL_BITS'(half_br[RECIP_HALF-1:0]);
                mul_b = MUL_BITS'(RECIP_THIRD[RECIP_BITS-1:RECIP_HALF]);
            end
            S_B2: begin
                mul_a = MUL_BITS'(half_br[RECIP_BITS-1:RECIP_HALF]);
                mul_b = MUL_BITS'(RECIP_THIRD[RECIP_HALF-1:0]);
            end
            S_B3: begin
                mul_a = MUL_BITS'(half_br[RECIP_BITS-1:RECIP_HALF]);
                mul_b = MUL_BITS'(RECIP_THIRD[RECIP_BITS-1:RECIP_HALF]);
            end
            S_B4: begin
                mul_a = MUL_BITS'(half_bl[RECIP_HALF-1:0]);
                mul_b = MUL_BITS'(RECIP_THIRD[RECIP_HALF-1:0]);
            end
            S_B5: begin
                mul_a = MUL_BITS'(half_bl[RECIP_HALF-1:0]);
                mul_b = MUL_BITS'(RECIP_THIRD[RECIP_BITS-1:RECIP_HALF]);
            end
            S_B6: begin
                mul_a = MUL_BITS'(half_bl[RECIP_BITS-1:RECIP_HALF]);
                mul_b = MUL_BITS'(RECIP_THIRD[RECIP_HALF-1:0]);
            end
            S_B7: begin
                mul_a = MUL_BITS'(half_bl[RECIP_BITS-1:RECIP_HALF]);
                mul_b = MUL_BITS'(RECIP_THIRD[RECIP_BITS-1:RECIP_HALF]);
            end
            S_P0: begin
                mul_a = MUL_BITS'(mag_lmr[LM_HALF-1:0]);
                mul_b = mag_dr;
            end
            S_P1: begin
                mul_a = MUL_BITS'(mag_lmr[2*LM_HALF-1:LM_HALF]);
                mul_b = mag_dr;
            end
            S_P2: begin
                mul_a = MUL_BITS'(mag_lml[LM_HALF-1:0]);
                mul_b = mag_dl;
            end
            S_P3: begin
                mul_a = MUL_BITS'(mag_lml[2*LM_HALF-1:LM_HALF]);
                mul_b = mag_dl;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            r_prod <= mul_a * mul_b;
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_pc    <= i_job.pc;
                        r_dl    <= t_slope'(i_job.pc) - t_slope'(i_job.pl);
                        r_dr    <= t_slope'(i_job.x) - t_slope'(i_job.pc);
                        r_var   <= i_job.var_index;
                        r_state <= S_SQ0;
                    end
                end
                S_SQ0: begin
                    r_state <= S_SQ1;
                end
                S_SQ1: begin
                    r_acc   <= ACC_BITS'(r_prod);
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    r_steep <= ((r_acc + ACC_BITS'(r_prod)) >= ACC_BITS'(i_smooth_threshold));
                    r_state <= S_TH;
                end
                S_TH: begin
                    r_state <= S_THW;
                end
                S_THW: begin
                    if (i_div_rsp.done) begin
                        r_th    <= ratio_out(i_div_rsp.quot, mag_dl == '0, mag_dr == '0,
                                             r_dl[SLOPE_BITS-1] != r_dr[SLOPE_BITS-1]);
                        r_state <= S_THI;
                    end
                end
                S_THI: begin
                    r_state <= S_THIW;
                end
                S_THIW: begin
                    if (i_div_rsp.done) begin
                        r_thi   <= ratio_out(i_div_rsp.quot, mag_dr == '0, mag_dl == '0,
                                             r_dl[SLOPE_BITS-1] != r_dr[SLOPE_BITS-1]);
                        r_state <= S_B0;
                    end
                end
                // Right base: four partial products of half the sum and the reciprocal of three
                S_B0: begin
                    r_state <= S_B1;
                end
                S_B1: begin
                    r_bacc  <= BACC_BITS'(r_prod);
                    r_state <= S_B2;
                end
                S_B2: begin
                    r_bacc  <= r_bacc + (BACC_BITS'(r_prod) << RECIP_HALF);
                    r_state <= S_B3;
                end
                S_B3: begin
                    r_bacc  <= r_bacc + (BACC_BITS'(r_prod) << RECIP_HALF);
                    r_state <= S_B4;
                end
                S_B4: begin
                    r_br    <= sum_br[RATIO_BITS-1] ? -t_ratio'(base_mag) : t_ratio'(base_mag);
                    r_state <= S_B5;
                end
                // Left base, the same way
                S_B5: begin
                    r_bacc  <= BACC_BITS'(r_prod);
                    r_state <= S_B6;
                end
                S_B6: begin
                    r_bacc  <= r_bacc + (BACC_BITS'(r_prod) << RECIP_HALF);
                    r_state <= S_B7;
                end
                S_B7: begin
                    r_bacc  <= r_bacc + (BACC_BITS'(r_prod) << RECIP_HALF);
                    r_state <= S_B8;
                end
                S_B8: begin
                    r_bl    <= sum_bl[RATIO_BITS-1] ? -t_ratio'(base_mag) : t_ratio'(base_mag);
                    r_state <= S_LIM;
                end
                S_LIM: begin
                    r_lmr   <= limit(r_th, r_br, i_limiter_mode, r_steep);
                    r_lml   <= limit(r_thi, r_bl, i_limiter_mode, r_steep);
                    r_state <= S_P0;
                end
                S_P0: begin
                    r_state <= S_P1;
                end
                S_P1: begin
                    r_acc   <= ACC_BITS'(r_prod);
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_acc_r <= r_acc + (ACC_BITS'(r_prod) << LM_HALF);
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_acc   <= ACC_BITS'(r_prod);
                    r_state <= S_P4;
                end
                S_P4: begin
                    r_acc_l <= r_acc + (ACC_BITS'(r_prod) << LM_HALF);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_left    <= sat_sample(WIDE_BITS'(r_pc) + prod_r);
                        r_right   <= sat_sample(WIDE_BITS'(r_pc) - prod_l);
                        r_out_var <= r_var;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/third_order_limited_reconstruction.sv -----
// Channel   Handshake             Payload
// input     push / full           i_sample, i_var_index, i_line_start
// result    empty / pop           o_left_state, o_right_state, o_out_var_index
// config    i_cfg_we              i_cfg_index, i_cfg_data
//
// A sample is accepted and, when it completes a three-cell window, queued in the same cycle.
// The back end takes one queued cell at a time through the squared-slope test,
// two slope-ratio divisions on the shared divider, the divisions by six by reciprocal
// multiplication, the limiter and the products.
// Synchronous active-low reset clears the control state and the configuration registers.
// Input and result sides stall independently through a two-entry queue and the result register.
module third_order_limited_reconstruction
    import tolr_pkg::*;
#(
    parameter int NUM_VARS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  t_sample                 i_sample,
    input  logic [VAR_BITS-1:0]     i_var_index,
    input  logic                    i_line_start,
    output logic                    empty,
    input  logic                    pop,
    output t_sample                 o_left_state,
    output t_sample                 o_right_state,
    output logic [VAR_BITS-1:0]     o_out_var_index,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [THR_BITS-1:0]     i_cfg_data
);

    logic                r_limiter_mode;
    logic [THR_BITS-1:0] r_smooth_threshold;
    logic                job_push;
    t_job                job_in;
    t_job                job_out;
    logic                q_full;
    logic                q_empty;
    logic                job_pop;
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    assign full = q_full;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limiter_mode     <= 1'b0;
            r_smooth_threshold <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LIMITER_MODE:     r_limiter_mode     <= i_cfg_data[0];
                CFG_SMOOTH_THRESHOLD: r_smooth_threshold <= i_cfg_data;
                default: begin
                    r_limiter_mode <= r_limiter_mode;
                end
            endcase
        end
    end

    tolr_front #(
        .NUM_VARS (NUM_VARS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_sample     (i_sample),
        .i_var_index  (i_var_index),
        .i_line_start (i_line_start),
        .i_q_full     (q_full),
        .o_job_push   (job_push),
        .o_job        (job_in)
    );

    tolr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (q_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (q_empty)
    );

    tolr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    tolr_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_job_valid        (!q_empty),
        .i_job              (job_out),
        .o_job_pop          (job_pop),
        .i_limiter_mode     (r_limiter_mode),
        .i_smooth_threshold (r_smooth_threshold),
        .o_div_req          (div_req),
        .i_div_rsp          (div_rsp),
        .o_empty            (empty),
        .i_pop              (pop),
        .o_left_state       (o_left_state),
        .o_right_state      (o_right_state),
        .o_out_var_index    (o_out_var_index)
    );

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
    import tolr_pkg::*;

    localparam int NVARS          = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 300;
    localparam longint RMAX       = (64'sd1 <<< (RATIO_INT_BITS + FRAC_BITS)) - 1;
    localparam longint Q_ONE      = 64'sd1 <<< FRAC_BITS;
    localparam longint Q_TWO      = 64'sd2 <<< FRAC_BITS;
    localparam longint Q_EIGHT    = (8 * Q_ONE + 5) / 10;
    localparam logic [THR_BITS-1:0] THR_TOP = '1;

    typedef struct {
        t_sample             left;
        t_sample             right;
        logic [VAR_BITS-1:0] vidx;
    } t_pair;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    push = 1'b0;
    logic                    full;
    t_sample                 i_sample = '0;
    logic [VAR_BITS-1:0]     i_var_index = '0;
    logic                    i_line_start = 1'b0;
    logic                    empty;
    logic                    pop = 1'b0;
    t_sample                 o_left_state;
    t_sample                 o_right_state;
    logic [VAR_BITS-1:0]     o_out_var_index;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [THR_BITS-1:0]     i_cfg_data = '0;

    // Predictor state and expected pairs
    longint              one_back [NVARS];
    longint              two_back [NVARS];
    int                  cells_full;
    bit                  limo3_on;
    logic [THR_BITS-1:0] steep_thr;
    t_pair               pair_queue [$];
    longint              last_val [NVARS];

    int  errors;
    bit  idling_on;
    int  quiet_cycles;
    int  pop_stall;

    third_order_limited_reconstruction #(.NUM_VARS(NVARS)) i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint unsigned magnitude(longint a);
        return (a < 0) ? longint'(-a) : longint'(a);
    endfunction

    // Slope ratio with saturation; a zero denominator counts as positive.
    function automatic longint slope_ratio(longint num, longint den);
        longint unsigned n, d, q;
        bit neg;
        n   = magnitude(num);
        d   = magnitude(den);
        neg = (num < 0) != (den < 0);
        if (n == 0) return 0;
        if (d == 0 || (n / d) > (longint'(RMAX) >>> FRAC_BITS))
            return neg ? -RMAX : RMAX;
        q = (n << FRAC_BITS) / d;
        if (q > RMAX) q = RMAX;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint scaled_product(longint lm, longint s);
        logic [127:0] p;
        bit neg;
        neg = (lm < 0) != (s < 0);
        p = ({64'd0, magnitude(lm)} * {64'd0, magnitude(s)}) >> FRAC_BITS;
        if (p > (128'd1 << 62)) p = 128'd1 << 62;
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint limiter(longint t, bit limo3, bit steep);
        longint base, p;
        base = (Q_TWO + t) / 6;
        if (!limo3) begin
            p = (t < base) ? t : base;
            p = (p < Q_ONE) ? p : Q_ONE;
            return (p > 0) ? p : 0;
        end
        if (!steep) return base;
        p = (t < Q_EIGHT) ? t : Q_EIGHT;
        p = (base < p) ? base : p;
        p = (-(t / 4) > p) ? -(t / 4) : p;
        p = (base < p) ? base : p;
        return (p > 0) ? p : 0;
    endfunction

    function automatic t_sample clamp_sample(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return t_sample'(v);
    endfunction

    // Advance the predictor by one accepted sample and queue any expected pair.
    function automatic void reconstruct_cell(t_sample s, logic [VAR_BITS-1:0] v, logic ls);
        longint x, dl, dr, lmr, lml;
        logic [127:0] sq;
        bit steep;
        t_pair pr;
        x = longint'(s);
        if (ls) cells_full = 0;
        if (cells_full >= 2) begin
            dl = one_back[v] - two_back[v];
            dr = x - one_back[v];
            sq = {64'd0, magnitude(dl)} * {64'd0, magnitude(dl)}
               + {64'd0, magnitude(dr)} * {64'd0, magnitude(dr)};
            steep = limo3_on && (sq[127:64] != 0 || sq[63:0] >= {2'b00, steep_thr});
            lmr = limiter(slope_ratio(dl, dr), limo3_on, steep);
            lml = limiter(slope_ratio(dr, dl), limo3_on, steep);
            pr.left  = clamp_sample(one_back[v] + scaled_product(lmr, dr));
            pr.right = clamp_sample(one_back[v] - scaled_product(lml, dl));
            pr.vidx  = v;
            pair_queue.push_back(pr);
        end
        two_back[v] = one_back[v];
        one_back[v] = x;
        if (v == NVARS - 1 && cells_full < 2) cells_full++;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
        errors++;
    endtask

    // Send one sample; push stays high afterwards so back-to-back transactions are possible.
    task automatic send_sample(t_sample s, logic [VAR_BITS-1:0] v, logic ls);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_sample     <= s;
        i_var_index  <= v;
        i_line_start <= ls;
        do @(posedge i_clk); while (full);
        reconstruct_cell(s, v, ls);
        last_val[v] = longint'(s);
    endtask

    // Hold off the sender until every expected pair has been taken, then let the block settle.
    task automatic drain;
        push <= 1'b0;
        @(posedge i_clk);
        while (pair_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [THR_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_LIMITER_MODE) limo3_on = data[0];
        else steep_thr = data;
    endtask

    // Two whole cells of a new slice, so every variable's store holds real samples.
    task automatic fill_slice;
        for (int c = 0; c < 2; c++)
            for (int v = 0; v < NVARS; v++)
                send_sample(t_sample'($urandom), VAR_BITS'(v), (c == 0 && v == 0));
    endtask

    task automatic directed_run;
        t_sample seq [$];
        seq = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0,
                32'h0001_0000, 32'h0001_0000, 32'h0003_0000, 32'h0002_0000,
                32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
        foreach (seq[k]) send_sample(seq[k], k % 2 ? 3'd7 : 3'd0, 1'b0);
        // A new slice gives no pairs for its first two cells.
        send_sample(32'h1234_5678, 3'd0, 1'b1);
        send_sample(32'h0, 3'd7, 1'b0);
    endtask

    task automatic test_directed_koren;
        write_reg(CFG_LIMITER_MODE, '0);
        write_reg(CFG_SMOOTH_THRESHOLD, '0);
        fill_slice();
        directed_run();
        drain();
    endtask

    task automatic test_directed_limo3;
        write_reg(CFG_LIMITER_MODE, 62'd1);
        fill_slice();
        directed_run();
        drain();
        write_reg(CFG_SMOOTH_THRESHOLD, THR_TOP);
        fill_slice();
        directed_run();
        drain();
    endtask

    function automatic t_sample pick_sample(int v);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return t_sample'(last_val[v] + ($signed($urandom_range(0, 4000)) - 2000) * 64);
        if (r < 55) return t_sample'(last_val[v]);
        if (r < 70) return t_sample'($urandom);
        if (r < 80) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        return t_sample'($signed($urandom_range(0, 1 << 20)) - (1 << 19)) <<< $urandom_range(0, 10);
    endfunction

    // Mostly whole cells in order, with some stray samples and slice restarts mixed in.
    task automatic test_random(bit mode, logic [THR_BITS-1:0] thr, int n_items, bit idle);
        int sent;
        idling_on = idle;
        write_reg(CFG_LIMITER_MODE, THR_BITS'(mode));
        write_reg(CFG_SMOOTH_THRESHOLD, thr);
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 85) begin
                for (int v = 0; v < NVARS; v++)
                    send_sample(pick_sample(v), VAR_BITS'(v),
                                (v == 0 && $urandom_range(0, 9) == 0));
                sent += NVARS;
            end else begin
                send_sample(t_sample'($urandom), VAR_BITS'($urandom_range(0, NVARS - 1)),
                            $urandom_range(0, 3) == 0);
                sent++;
            end
        end
        drain();
    endtask

    // Result side: check each accepted pair, then choose the next pop, with random stalls when idling_on is set.
    always @(posedge i_clk) begin
        t_pair want;
        if (!i_rst_n) begin
            pop <= 1'b0;
            pop_stall = 0;
        end else begin
            if (pop && !empty) begin
                if (pair_queue.size() == 0) begin
                    report_mismatch("unexpected pair, variable", longint'(o_out_var_index), 0);
                end else begin
                    want = pair_queue.pop_front();
                    if (o_left_state !== want.left)
                        report_mismatch("left_state", longint'(o_left_state),
                                        longint'(want.left));
                    if (o_right_state !== want.right)
                        report_mismatch("right_state", longint'(o_right_state),
                                        longint'(want.right));
                    if (o_out_var_index !== want.vidx)
                        report_mismatch("out_var_index", longint'(o_out_var_index),
                                        longint'(want.vidx));
                end
            end
            if (pop_stall > 0) begin
                pop_stall--;
                pop <= 1'b0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                pop_stall = $urandom_range(0, 18);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        logic [THR_BITS-1:0] thr;
        errors     = 0;
        idling_on  = 1'b1;
        cells_full = 0;
        limo3_on   = 1'b0;
        steep_thr  = '0;
        for (int v = 0; v < NVARS; v++) begin
            one_back[v] = 0;
            two_back[v] = 0;
            last_val[v] = 0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_koren();
        test_directed_limo3();
        test_random(1'b0, '0, 120, 1'b1);
        test_random(1'b1, '0, 120, 1'b1);
        test_random(1'b1, THR_TOP, 80, 1'b1);
        thr = THR_BITS'({$urandom, $urandom} >> $urandom_range(2, 40));
        test_random(1'b1, thr, 120, 1'b1);
        test_random(1'b0, THR_BITS'($urandom), 120, 1'b0);

        if (pair_queue.size() != 0) begin
            report_mismatch("expected pairs never arrived", longint'(pair_queue.size()), 0);
        end
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- third_order_limited_reconstruction.f -----
rtl/core/tolr_pkg.sv
rtl/core/tolr_fifo.sv
rtl/core/tolr_front.sv
rtl/core/tolr_div.sv
rtl/core/tolr_back.sv
rtl/core/third_order_limited_reconstruction.sv
verif/tb_top.sv
